### rtl/wavhp_pkg.sv
// Package for the WAV header parser: beat types, status codes, register
// indexes, reset values and the chunk signatures.
// No dependencies; every other file of the block imports it.
package wavhp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [4:0]  sample_bits;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [31:0] riff_size;
    logic [31:0] data_size;
  } out_beat_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TRUNCATED   = 3'd1;
  localparam logic [2:0] ST_RIFF        = 3'd2;
  localparam logic [2:0] ST_FMT_HEADER  = 3'd3;
  localparam logic [2:0] ST_FORMAT      = 3'd4;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd5;
  localparam logic [2:0] ST_INCONSIST   = 3'd6;
  localparam logic [2:0] ST_DATA_HEADER = 3'd7;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CHANNELS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_SAMPLE_RATE = 2'd1;

  localparam logic [7:0]  MAX_CHANNELS_RESET    = 8'd2;
  localparam logic [23:0] MAX_SAMPLE_RATE_RESET = 24'd48000;

  localparam logic [5:0] POS_RIFF_END = 6'd11;
  localparam logic [5:0] POS_FMT_END  = 6'd19;
  localparam logic [5:0] POS_MUL      = 6'd34;
  localparam logic [5:0] POS_BODY_END = 6'd35;
  localparam logic [5:0] POS_LAST     = 6'd43;

  localparam logic [31:0] SIG_RIFF = "RIFF";
  localparam logic [31:0] SIG_WAVE = "WAVE";
  localparam logic [31:0] SIG_FMT  = "fmt ";
  localparam logic [31:0] SIG_DATA = "data";

  localparam logic [31:0] FMT_SIZE_PCM = 32'd16;
  localparam logic [15:0] FORMAT_PCM   = 16'd1;
  localparam logic [15:0] BITS_8       = 16'd8;
  localparam logic [15:0] BITS_16      = 16'd16;

  // Signature words, indexed by the 4-byte group that the position falls in.
  function automatic logic [31:0] sig_word(input logic [3:0] grp);
    logic [31:0] w;
    case (grp)
      4'd0:    w = SIG_RIFF;
      4'd2:    w = SIG_WAVE;
      4'd3:    w = SIG_FMT;
      default: w = SIG_DATA;
    endcase
    return w;
  endfunction

  function automatic logic is_sig_pos(input logic [5:0] p);
    return (p[5:2] == 4'd0) || (p[5:2] == 4'd2) || (p[5:2] == 4'd3) ||
           (p[5:2] == 4'd9);
  endfunction

endpackage

### rtl/wav_header_parser_core.sv
// Top level of the WAV header parser: configuration registers, parser and
// result buffer.  Depends on wavhp_pkg, wavhp_parser and wavhp_out_buf.
//
// Usage: file bytes arrive on the byte channel (byte_valid, byte_stall,
// byte_data), one beat per byte, with first_byte set on byte 0 of a file
// and last_byte on the final byte of the stream.  One result beat per file
// leaves on the result channel (result_valid, result_stall, result_data):
// at the first failed check, at byte 43 on success, or on truncation.
// Bytes after the result are dropped until the next first_byte.
// Throughput is one byte per cycle while byte_stall is low; the only
// arithmetic is a 32 by 16 bit multiply registered one byte ahead of
// its check.  Results are registered in the output register or skid stage.
// When the receiver stalls, the output register and one skid stage hold
// up to two results; byte_stall rises only while the skid stage is full.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 sets the channel limit, index 1 the sample rate
// limit, other indexes are ignored.
// Reset (rst, synchronous) restores the limits to 2 and 48000 Hz, empties
// the result buffer and leaves the parser idle until a first byte.
module wav_header_parser_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  byte_valid,
  output logic                                  byte_stall,
  input  wavhp_pkg::in_beat_t                   byte_data,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output wavhp_pkg::out_beat_t                  result_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wavhp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [23:0]                           cfg_data
);
  import wavhp_pkg::*;

  logic [7:0]  max_channels;
  logic [23:0] max_sample_rate;
  logic        accept;
  logic        res_valid;
  out_beat_t   res;

  assign cfg_ready = 1'b1;
  assign accept    = byte_valid & ~byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_channels    <= MAX_CHANNELS_RESET;
      max_sample_rate <= MAX_SAMPLE_RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_CHANNELS:    max_channels    <= cfg_data[7:0];
        REG_MAX_SAMPLE_RATE: max_sample_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  wavhp_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .beat            (byte_data),
    .max_channels    (max_channels),
    .max_sample_rate (max_sample_rate),
    .res_valid       (res_valid),
    .res             (res)
  );

  wavhp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (byte_stall),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_data  (result_data)
  );

endmodule

### rtl/wavhp_parser.sv
// Header parser: byte position counter, field capture and the checks made
// at the end of each header part.  Depends on wavhp_pkg.
module wavhp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  wavhp_pkg::in_beat_t beat,
  input  logic [7:0]          max_channels,
  input  logic [23:0]         max_sample_rate,
  output logic                res_valid,
  output wavhp_pkg::out_beat_t res
);
  import wavhp_pkg::*;

  logic [5:0]  pos;
  logic        finished;
  logic        sig_mis;
  logic [31:0] fmt_size;
  logic [15:0] format_tag;
  logic [15:0] channels;
  logic [31:0] rate;
  logic [31:0] brate;
  logic [15:0] align;
  logic [15:0] bits;
  logic [31:0] riff_size;
  logic [31:0] data_size;
  logic [31:0] want_rate;

  logic        active;
  logic [5:0]  p;
  logic [7:0]  b;
  logic        mis_acc;
  logic        hit;
  logic [2:0]  code;
  logic [31:0] fmt_size_full;
  logic [15:0] bits_full;
  logic [31:0] data_size_full;
  logic [15:0] want_align;
  logic [31:0] sig;
  logic        unsupported;

  always_comb begin
    active         = beat.first_byte | ~finished;
    p              = beat.first_byte ? 6'd0 : pos;
    b              = beat.data_byte;
    sig            = sig_word(p[5:2]);
    mis_acc        = (beat.first_byte ? 1'b0 : sig_mis) |
                     (is_sig_pos(p) && (b != sig[31 - 8*p[1:0] -: 8]));
    fmt_size_full  = {b, fmt_size[23:0]};
    bits_full      = {b, bits[7:0]};
    data_size_full = {b, data_size[23:0]};
    // Block align is only compared once bits is known to be 8 or 16.
    want_align     = (bits_full == BITS_8) ? channels : {channels[14:0], 1'b0};
    unsupported    = (channels == 16'd0) || (channels > {8'd0, max_channels}) ||
                     (rate == 32'd0) || (rate > {8'd0, max_sample_rate}) ||
                     !((bits_full == BITS_8) || (bits_full == BITS_16));
    hit  = 1'b0;
    code = ST_OK;
    if (p == POS_RIFF_END) begin
      if (mis_acc) begin
        hit  = 1'b1;
        code = ST_RIFF;
      end
    end else if (p == POS_FMT_END) begin
      if (mis_acc || fmt_size_full != FMT_SIZE_PCM) begin
        hit  = 1'b1;
        code = ST_FMT_HEADER;
      end
    end else if (p == POS_BODY_END) begin
      if (format_tag != FORMAT_PCM) begin
        hit  = 1'b1;
        code = ST_FORMAT;
      end else if (unsupported) begin
        hit  = 1'b1;
        code = ST_UNSUPPORTED;
      end else if (align != want_align || brate != want_rate) begin
        hit  = 1'b1;
        code = ST_INCONSIST;
      end
    end else if (p == POS_LAST) begin
      hit  = 1'b1;
      code = mis_acc ? ST_DATA_HEADER : ST_OK;
    end
    if (!hit && beat.last_byte) begin
      hit  = 1'b1;
      code = ST_TRUNCATED;
    end

    res_valid = accept & active & hit;
    res       = '0;
    res.status = code;
    if (code == ST_OK) begin
      res.channel_count = channels;
      res.sample_rate   = rate;
      res.sample_bits   = bits_full[4:0];
      res.byte_rate     = brate;
      res.block_align   = align;
      res.riff_size     = riff_size;
      res.data_size     = data_size_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= 6'd0;
      finished <= 1'b1;
      sig_mis  <= 1'b0;
    end else if (accept && active) begin
      pos      <= (p < POS_LAST) ? p + 6'd1 : p;
      finished <= hit;
      sig_mis  <= (p == POS_RIFF_END || p == POS_FMT_END) ? 1'b0 : mis_acc;
    end
  end

  // Every field byte is rewritten before it is used, so the capture
  // registers need no clearing on a new file.
  always_ff @(posedge clk) begin
    if (accept && active) begin
      if (p >= 6'd4 && p <= 6'd7)   riff_size[8*p[1:0] +: 8]  <= b;
      if (p >= 6'd16 && p <= 6'd19) fmt_size[8*p[1:0] +: 8]   <= b;
      if (p >= 6'd20 && p <= 6'd21) format_tag[8*p[0] +: 8]   <= b;
      if (p >= 6'd22 && p <= 6'd23) channels[8*p[0] +: 8]     <= b;
      if (p >= 6'd24 && p <= 6'd27) rate[8*p[1:0] +: 8]       <= b;
      if (p >= 6'd28 && p <= 6'd31) brate[8*p[1:0] +: 8]      <= b;
      if (p >= 6'd32 && p <= 6'd33) align[8*p[0] +: 8]        <= b;
      if (p >= 6'd34 && p <= 6'd35) bits[8*p[0] +: 8]         <= b;
      if (p >= 6'd40 && p <= 6'd43) data_size[8*p[1:0] +: 8]  <= b;
      // Rate and align are complete by now; the product is ready for the
      // consistency check one byte later.
      if (p == POS_MUL) begin
        want_rate <= 32'(rate * {16'd0, align});
      end
    end
  end

endmodule

### rtl/wavhp_out_buf.sv
// Result output register with one skid stage, so the parser keeps taking
// bytes while a result waits.  Depends on wavhp_pkg.
module wavhp_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  wavhp_pkg::out_beat_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wavhp_pkg::out_beat_t out_data
);
  import wavhp_pkg::*;

  logic      main_valid;
  logic      skid_valid;
  out_beat_t main_data;
  out_beat_t skid_data;
  logic      pop;

  assign pop       = main_valid & ~out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (!main_valid) begin
      main_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      main_data <= skid_data;
    end else if (pop || !main_valid) begin
      main_data <= push_data;
    end
    if (!pop && main_valid && push) begin
      skid_data <= push_data;
    end
  end

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid stage holds a result while the output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && skid_valid))
    else $error("result pushed while the skid stage is occupied");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && skid_valid) |=> (main_valid && !skid_valid))
    else $error("skid stage did not move into the output register");

endmodule
